@@ hw/rtl/swm_pkg.sv @@
// Shared types and constants for the sensor window monitor.
package swm_pkg;

  localparam int SAMPLE_W = 10;
  localparam int PERIOD_W = 4;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [SAMPLE_W-1:0] LOW_LIMIT_RST    = 10'd10;
  localparam logic [SAMPLE_W-1:0] HIGH_LIMIT_RST   = 10'd1013;
  localparam logic [SAMPLE_W-1:0] SPREAD_LIMIT_RST = 10'd500;
  localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RST = 4'd4;
  localparam logic [SAMPLE_W-1:0] WIN_MIN_RST      = 10'd1023;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_CHECK  = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_LIMIT    = 2'd0,
    REG_HIGH_LIMIT   = 2'd1,
    REG_SPREAD_LIMIT = 2'd2,
    REG_BLINK_PERIOD = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] low_limit;
    logic [SAMPLE_W-1:0] high_limit;
    logic [SAMPLE_W-1:0] spread_limit;
    logic [PERIOD_W-1:0] blink_period;
  } cfg_t;

  typedef struct packed {
    logic                led_on;
    logic                out_of_range;
    logic                spread_alarm;
    logic [SAMPLE_W-1:0] spread;
    logic                sample_dropped;
  } result_t;

endpackage

@@ hw/rtl/swm_if.sv @@
// Valid/ready channel interfaces for input words, result words and config writes.
interface swm_in_if;
  logic                          valid;
  logic                          ready;
  logic [swm_pkg::KIND_W-1:0]    kind;
  logic [swm_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output kind, output sample, input ready);
  modport sink   (input valid, input kind, input sample, output ready);
endinterface

interface swm_out_if;
  logic                          valid;
  logic                          ready;
  logic                          led_on;
  logic                          out_of_range;
  logic                          spread_alarm;
  logic [swm_pkg::SAMPLE_W-1:0]  spread;
  logic                          sample_dropped;

  modport source (output valid, output led_on, output out_of_range, output spread_alarm,
                  output spread, output sample_dropped, input ready);
  modport sink   (input valid, input led_on, input out_of_range, input spread_alarm,
                  input spread, input sample_dropped, output ready);
endinterface

interface swm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [swm_pkg::CFG_IDX_W-1:0]   index;
  logic [swm_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/sensor_window_monitor_led_top.sv @@
// Top level of the sensor window monitor with LED driver.
// Usage:
//   in_port  : valid/ready words carrying kind (0 sample, 1 window check,
//              2 LED tick, 3 no-op) and a 10-bit sample.
//   out_port : one result word per input word: LED level, out-of-range,
//              spread alarm, window spread and sample-dropped flags.
//   cfg_port : register writes (0 low limit, 1 high limit, 2 spread limit,
//              3 slow blink period); always ready, take effect next cycle.
//   Pipeline: a word accepted on in_port passes through the input register,
//   then the result register, before its result is valid on out_port.
//   Throughput: one word per cycle while out_port does not stall; the single
//   update path from input register to result register sets that figure.
//   Reset (rst_n low, synchronous): window empty, flags clear, LED lit,
//   registers at their defaults, both pipeline stages empty.
//   When out_port stalls the result register holds, the input register
//   still takes one more word, and in_port.ready then drops until the
//   receiver takes the result.
module sensor_window_monitor_led_top #(
  parameter int WINDOW_DEPTH = 5
) (
  input  logic      clk,
  input  logic      rst_n,
  swm_in_if.sink    in_port,
  swm_out_if.source out_port,
  swm_cfg_if.sink   cfg_port
);
  import swm_pkg::*;

  logic                in_valid_r;
  logic [KIND_W-1:0]   kind_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic                out_valid_r;
  result_t             res_r;
  result_t             res_nxt;
  cfg_t                cfg;
  logic                advance;

  assign advance       = in_valid_r && (!out_valid_r || out_port.ready);
  assign in_port.ready = !in_valid_r || advance;

  swm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_port (cfg_port),
    .cfg      (cfg)
  );

  swm_core #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .kind    (kind_r),
    .sample  (sample_r),
    .cfg     (cfg),
    .result  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_port.ready) in_valid_r <= in_port.valid;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_port.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_port.valid && in_port.ready) begin
      kind_r   <= in_port.kind;
      sample_r <= in_port.sample;
    end
    if (advance) res_r <= res_nxt;
  end

  assign out_port.valid          = out_valid_r;
  assign out_port.led_on         = res_r.led_on;
  assign out_port.out_of_range   = res_r.out_of_range;
  assign out_port.spread_alarm   = res_r.spread_alarm;
  assign out_port.spread         = res_r.spread;
  assign out_port.sample_dropped = res_r.sample_dropped;

endmodule

@@ hw/rtl/swm_cfg.sv @@
// Configuration register file for limits and blink period.
module swm_cfg (
  input  logic          clk,
  input  logic          rst_n,
  swm_cfg_if.sink       cfg_port,
  output swm_pkg::cfg_t cfg
);
  import swm_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_port.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_port.valid) begin
      unique case (cfg_idx_t'(cfg_port.index))
        REG_LOW_LIMIT:    cfg_nxt.low_limit    = cfg_port.data[SAMPLE_W-1:0];
        REG_HIGH_LIMIT:   cfg_nxt.high_limit   = cfg_port.data[SAMPLE_W-1:0];
        REG_SPREAD_LIMIT: cfg_nxt.spread_limit = cfg_port.data[SAMPLE_W-1:0];
        REG_BLINK_PERIOD: cfg_nxt.blink_period = cfg_port.data[PERIOD_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_limit    <= LOW_LIMIT_RST;
      cfg_r.high_limit   <= HIGH_LIMIT_RST;
      cfg_r.spread_limit <= SPREAD_LIMIT_RST;
      cfg_r.blink_period <= BLINK_PERIOD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hw/rtl/swm_core.sv @@
// Window min/max/count, range and alarm flags, LED blink state and result logic.
module swm_core #(
  parameter int WINDOW_DEPTH = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  logic [swm_pkg::KIND_W-1:0]    kind,
  input  logic [swm_pkg::SAMPLE_W-1:0]  sample,
  input  swm_pkg::cfg_t                 cfg,
  output swm_pkg::result_t              result
);
  import swm_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(WINDOW_DEPTH);

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SAMPLE_W-1:0] min_r, min_nxt;
  logic [SAMPLE_W-1:0] max_r, max_nxt;
  logic                range_r, range_nxt;
  logic                alarm_r, alarm_nxt;
  logic                led_r, led_nxt;
  logic [PERIOD_W-1:0] blink_r, blink_nxt;

  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W:0]   blink_inc;
  logic [SAMPLE_W-1:0] spread;
  logic                dropped;

  assign period    = (cfg.blink_period == '0) ? PERIOD_W'(1) : cfg.blink_period;
  assign blink_inc = {1'b0, blink_r} + (PERIOD_W+1)'(1);

  always_comb begin
    count_nxt = count_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    range_nxt = range_r;
    alarm_nxt = alarm_r;
    led_nxt   = led_r;
    blink_nxt = blink_r;
    spread    = '0;
    dropped   = 1'b0;
    unique case (kind_t'(kind))
      KIND_SAMPLE: begin
        if (count_r >= DEPTH_C) begin
          dropped = 1'b1;
        end else begin
          if (sample < min_r) min_nxt = sample;
          if (sample > max_r) max_nxt = sample;
          count_nxt = count_r + CNT_W'(1);
        end
        range_nxt = (sample < cfg.low_limit) || (sample > cfg.high_limit);
      end
      KIND_CHECK: begin
        if (count_r == '0) begin
          alarm_nxt = 1'b0;
        end else begin
          spread    = max_r - min_r;
          alarm_nxt = spread > cfg.spread_limit;
        end
        count_nxt = '0;
        min_nxt   = WIN_MIN_RST;
        max_nxt   = '0;
      end
      KIND_TICK: begin
        if (range_r) begin
          blink_nxt = '0;
          led_nxt   = ~led_r;
        end else if (alarm_r) begin
          if (blink_r == '0) led_nxt = ~led_r;
          blink_nxt = (blink_inc >= {1'b0, period}) ? '0 : blink_inc[PERIOD_W-1:0];
        end else begin
          blink_nxt = '0;
          led_nxt   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result.led_on         = led_nxt;
    result.out_of_range   = range_nxt;
    result.spread_alarm   = alarm_nxt;
    result.spread         = spread;
    result.sample_dropped = dropped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      min_r   <= WIN_MIN_RST;
      max_r   <= '0;
      range_r <= 1'b0;
      alarm_r <= 1'b0;
      led_r   <= 1'b1;
      blink_r <= '0;
    end else if (advance) begin
      count_r <= count_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      range_r <= range_nxt;
      alarm_r <= alarm_nxt;
      led_r   <= led_nxt;
      blink_r <= blink_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("window count above depth");

  a_check_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && kind_t'(kind) == KIND_CHECK) |=> (count_r == '0 && max_r == '0))
    else $error("window not cleared by check");

  a_nonempty_order: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (max_r >= min_r))
    else $error("window max below min");

  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && result.sample_dropped) |=> $stable(count_r))
    else $error("dropped sample changed window count");

endmodule

@@ verif/swm_check_pkg.sv @@
// Result predictor and checker for the sensor window monitor testbench.
`timescale 1ns / 100ps
package swm_check_pkg;
  import swm_pkg::*;

  class window_led_checker;
    logic [SAMPLE_W-1:0] low_limit;
    logic [SAMPLE_W-1:0] high_limit;
    logic [SAMPLE_W-1:0] spread_limit;
    logic [PERIOD_W-1:0] blink_period;

    int unsigned         depth;
    int unsigned         win_count;
    logic [SAMPLE_W-1:0] win_min;
    logic [SAMPLE_W-1:0] win_max;
    logic                range_err;
    logic                alarm;
    logic                led;
    logic [PERIOD_W-1:0] blink_cnt;

    result_t pending_status[$];

    int unsigned n_checked;
    int unsigned n_mismatch;
    int unsigned n_dropped;
    int unsigned n_alarms;
    int unsigned n_oor;
    int unsigned n_toggles;

    function new(int unsigned window_depth);
      depth        = window_depth;
      low_limit    = LOW_LIMIT_RST;
      high_limit   = HIGH_LIMIT_RST;
      spread_limit = SPREAD_LIMIT_RST;
      blink_period = BLINK_PERIOD_RST;
      win_count    = 0;
      win_min      = WIN_MIN_RST;
      win_max      = '0;
      range_err    = 1'b0;
      alarm        = 1'b0;
      led          = 1'b1;
      blink_cnt    = '0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_LOW_LIMIT:    low_limit    = value[SAMPLE_W-1:0];
        REG_HIGH_LIMIT:   high_limit   = value[SAMPLE_W-1:0];
        REG_SPREAD_LIMIT: spread_limit = value[SAMPLE_W-1:0];
        REG_BLINK_PERIOD: blink_period = value[PERIOD_W-1:0];
      endcase
    endfunction

    function result_t predict_status(kind_t kind, logic [SAMPLE_W-1:0] x);
      result_t             r;
      logic [PERIOD_W:0]   next_blink;
      logic [PERIOD_W-1:0] period;
      logic                led_was;
      r = '0;
      led_was = led;
      case (kind)
        KIND_SAMPLE: begin
          if (win_count >= depth) begin
            r.sample_dropped = 1'b1;
            n_dropped++;
          end else begin
            if (x < win_min) win_min = x;
            if (x > win_max) win_max = x;
            win_count++;
          end
          range_err = (x < low_limit) || (x > high_limit);
          if (range_err) n_oor++;
        end
        KIND_CHECK: begin
          if (win_count == 0) begin
            alarm = 1'b0;
          end else begin
            r.spread = win_max - win_min;
            alarm = (r.spread > spread_limit);
          end
          if (alarm) n_alarms++;
          win_count = 0;
          win_min   = WIN_MIN_RST;
          win_max   = '0;
        end
        KIND_TICK: begin
          if (range_err) begin
            blink_cnt = '0;
            led = ~led;
          end else if (alarm) begin
            // zero period behaves as one
            period = (blink_period == '0) ? PERIOD_W'(1) : blink_period;
            next_blink = {1'b0, blink_cnt} + (PERIOD_W+1)'(1);
            if (blink_cnt == 0) led = ~led;
            blink_cnt = (next_blink >= {1'b0, period}) ? '0 : next_blink[PERIOD_W-1:0];
          end else begin
            blink_cnt = '0;
            led = 1'b0;
          end
          if (led != led_was) n_toggles++;
        end
        KIND_NONE: ;
      endcase
      r.led_on       = led;
      r.out_of_range = range_err;
      r.spread_alarm = alarm;
      return r;
    endfunction

    function void note_word(kind_t kind, logic [SAMPLE_W-1:0] x);
      pending_status.push_back(predict_status(kind, x));
    endfunction

    function int pending();
      return pending_status.size();
    endfunction

    function void report_miss(string why, result_t want, result_t got);
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("%s (word %0d): expected led=%b oor=%b alarm=%b spread=%0d drop=%b",
                 why, n_checked, want.led_on, want.out_of_range, want.spread_alarm,
                 want.spread, want.sample_dropped);
      if (n_mismatch <= 10)
        $display("  actual led=%b oor=%b alarm=%b spread=%0d drop=%b",
                 got.led_on, got.out_of_range, got.spread_alarm, got.spread,
                 got.sample_dropped);
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (pending_status.size() == 0) begin
        report_miss("unexpected result word", '0, got);
      end else begin
        want = pending_status.pop_front();
        n_checked++;
        if (got.led_on !== want.led_on || got.out_of_range !== want.out_of_range ||
            got.spread_alarm !== want.spread_alarm || got.spread !== want.spread ||
            got.sample_dropped !== want.sample_dropped)
          report_miss("result word mismatch", want, got);
      end
    endfunction
  endclass

endpackage

@@ verif/sensor_window_monitor_led_top_tb.sv @@
// Self-checking testbench for the sensor window monitor with LED driver.
`timescale 1ns / 100ps
module sensor_window_monitor_led_top_tb;
  import swm_pkg::*;
  import swm_check_pkg::*;

  localparam int WINDOW_DEPTH    = 5;
  localparam int RANDOM_PHASES   = 8;
  localparam int WORDS_PER_PHASE = 100;
  localparam int LONG_HOLD       = 150;
  localparam int CYCLE_LIMIT     = 200000;

  logic        clk;
  logic        rst_n;
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  int unsigned cycle_count;
  int unsigned words_counted;
  int unsigned settings_used;
  bit          hold_req;

  window_led_checker sb;

  swm_in_if  in_if ();
  swm_out_if out_if ();
  swm_cfg_if cfg_if ();

  sensor_window_monitor_led_top #(.WINDOW_DEPTH(WINDOW_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_if),
    .out_port (out_if),
    .cfg_port (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t got;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end else if (rst_n) begin
      if (in_if.valid && in_if.ready)
        sb.note_word(kind_t'(in_if.kind), in_if.sample);
      if (out_if.valid && out_if.ready) begin
        got.led_on         = out_if.led_on;
        got.out_of_range   = out_if.out_of_range;
        got.spread_alarm   = out_if.spread_alarm;
        got.spread         = out_if.spread;
        got.sample_dropped = out_if.sample_dropped;
        sb.check_word(got);
      end
    end
  end

  task automatic send_word(kind_t kind, logic [SAMPLE_W-1:0] x);
    while ($urandom_range(99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.kind   <= kind;
    in_if.sample <= x;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (kind != KIND_NONE) words_counted++;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic apply_setting(logic [SAMPLE_W-1:0] lo, logic [SAMPLE_W-1:0] hi,
                               logic [SAMPLE_W-1:0] spread, logic [PERIOD_W-1:0] period);
    logic [CFG_DATA_W-PERIOD_W-1:0] junk;
    junk = (CFG_DATA_W-PERIOD_W)'($urandom);
    write_reg(REG_LOW_LIMIT, lo);
    write_reg(REG_HIGH_LIMIT, hi);
    write_reg(REG_SPREAD_LIMIT, spread);
    write_reg(REG_BLINK_PERIOD, {junk, period});
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  // let the last accepted word be noted, wait for every pending result,
  // then the two-stage pipeline latency
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SAMPLE_W-1:0] centre);
    logic [SAMPLE_W-1:0] v;
    case ($urandom_range(0, 6))
      0, 1:    v = SAMPLE_W'($urandom_range(0, 1023));
      2:       v = sb.low_limit + SAMPLE_W'($urandom_range(0, 2)) - SAMPLE_W'(1);
      3:       v = sb.high_limit + SAMPLE_W'($urandom_range(0, 2)) - SAMPLE_W'(1);
      4:       v = $urandom_range(0, 1) ? '0 : '1;
      5:       v = centre;
      default: v = centre + sb.spread_limit + SAMPLE_W'($urandom_range(0, 2)) - SAMPLE_W'(1);
    endcase
    return v;
  endfunction

  // samples, mostly a window check, then LED ticks; now and then a stray word first
  task automatic run_burst();
    int unsigned         n_samples;
    int unsigned         n_ticks;
    logic [SAMPLE_W-1:0] centre;
    n_samples = $urandom_range(0, 7);
    n_ticks   = $urandom_range(0, 6);
    centre    = SAMPLE_W'($urandom_range(0, 1023 - sb.spread_limit));
    if ($urandom_range(0, 9) == 0)
      send_word(kind_t'($urandom_range(0, 3)), SAMPLE_W'($urandom_range(0, 1023)));
    repeat (n_samples) send_word(KIND_SAMPLE, pick_sample(centre));
    if ($urandom_range(0, 9) != 0) send_word(KIND_CHECK, SAMPLE_W'($urandom_range(0, 1023)));
    repeat (n_ticks) send_word(KIND_TICK, SAMPLE_W'($urandom_range(0, 1023)));
  endtask

  initial begin
    int unsigned         start;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] tmp;
    sb = new(WINDOW_DEPTH);
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.kind   <= KIND_SAMPLE;
    in_if.sample <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_LOW_LIMIT;
    cfg_if.data  <= '0;
    in_idle_pct   = 31;
    out_idle_pct  = 57;
    settings_used = 1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed, at reset register values
    send_word(KIND_TICK, 10'd0);
    send_word(KIND_CHECK, 10'd1023);
    send_word(KIND_SAMPLE, 10'd0);
    send_word(KIND_SAMPLE, 10'd1023);
    send_word(KIND_SAMPLE, 10'd10);
    send_word(KIND_SAMPLE, 10'd1013);
    send_word(KIND_SAMPLE, 10'd9);
    send_word(KIND_SAMPLE, 10'd1014);
    send_word(KIND_TICK, 10'd0);
    send_word(KIND_TICK, 10'd0);
    send_word(KIND_CHECK, 10'd0);
    send_word(KIND_NONE, 10'd1023);
    send_word(KIND_SAMPLE, 10'd500);
    send_word(KIND_CHECK, 10'd0);
    send_word(KIND_SAMPLE, 10'd11);
    send_word(KIND_SAMPLE, 10'd511);
    send_word(KIND_CHECK, 10'd0);
    send_word(KIND_SAMPLE, 10'd11);
    send_word(KIND_SAMPLE, 10'd512);
    send_word(KIND_CHECK, 10'd0);
    repeat (5) send_word(KIND_TICK, 10'd0);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 3) begin
        in_idle_pct  = 57;
        out_idle_pct = 31;
      end
      if (p == 6) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      case (p)
        0: apply_setting(10'd0, 10'd1023, 10'd0, 4'd1);
        1: apply_setting(10'd1023, 10'd0, 10'd1023, 4'd15);
        2: apply_setting(SAMPLE_W'($urandom_range(0, 200)), SAMPLE_W'($urandom_range(800, 1023)),
                         SAMPLE_W'($urandom_range(0, 1023)), 4'd0);
        default: begin
          lo = SAMPLE_W'($urandom_range(0, 1023));
          hi = SAMPLE_W'($urandom_range(0, 1023));
          if (lo > hi && $urandom_range(0, 3) != 0) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
          end
          apply_setting(lo, hi, SAMPLE_W'($urandom_range(0, 600)),
                        PERIOD_W'($urandom_range(0, 15)));
        end
      endcase
      // blink counter is left mid-cycle, not below the new period
      if (p == 0) send_word(KIND_TICK, 10'd0);
      if (p == 6) hold_req = 1'b1;
      start = words_counted;
      while (words_counted - start < WORDS_PER_PHASE) run_burst();
      settle();
    end

    $display("Checked %0d result words over %0d register settings and three idle mixes.",
             sb.n_checked, settings_used);
    $display("Saw %0d dropped samples, %0d alarmed checks, %0d out-of-range samples,",
             sb.n_dropped, sb.n_alarms, sb.n_oor);
    $display("  and %0d LED toggles.", sb.n_toggles);
    if (sb.n_mismatch == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results still pending", sb.n_mismatch, sb.pending());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
